// ===== design/tcf_pkg.sv =====
// Shared types, constants and the arctangent table for the tilt complementary filter.
`timescale 1ns / 1ps

package tcf_pkg;

  // Internal angle unit is 1/16384 degree
  localparam int ACC_W      = 23;   // filtered angle state
  localparam int ANG_W      = 24;   // CORDIC angle accumulator, gravity angle
  localparam int PRED_W     = 24;   // state plus gyro increment
  localparam int CORDIC_W   = 35;   // CORDIC x/y vector incl. gain growth
  localparam int TAB_IDX_W  = 5;
  localparam int TABLE_LEN  = 24;
  localparam int ANG_LIMIT  = 2949120;   // 180 degrees

  // Gyro increment: q = floor((|raw|*period*2048 + DIV_BIAS) / DIV_CONST)
  // estimate floor(|raw|*period*RECIP / 2^RECIP_SH), then one compare and add
  localparam int MAG_W      = 23;   // |raw|*period
  localparam int DIV_NUM_W  = 35;
  localparam int DIV_Q_BITS = 21;
  localparam int DIV_CONST  = 16375;
  localparam int DIV_BIAS   = 8187;
  localparam int RECIP      = 65572;   // floor(2^30 / DIV_CONST)
  localparam int RECIP_SH   = 19;
  localparam int GYRO_STEPS = 2;       // estimate, correction

  // Shared multiplier
  localparam int MUL_A_W    = 25;
  localparam int MUL_B_W    = 18;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;

  // Configuration register map
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_WEIGHT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD_MS = 2'd1;

  localparam logic [15:0] BLEND_WEIGHT_RST = 16'd3277;
  localparam logic [7:0]  PERIOD_MS_RST    = 8'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GYRO_MUL,
    ST_ITERATE,
    ST_PREDICT,
    ST_BLEND_MUL,
    ST_WRITE_BACK
  } tcf_state_t;

  // Control for the iterative units
  typedef struct packed {
    logic load;
    logic step;
  } tcf_iter_ctl_t;

  // atan(2^-i) in 1/16384 degree, rounded
  function automatic logic [ANG_W-1:0] atan_lookup(input logic [TAB_IDX_W-1:0] idx);
    logic [ANG_W-1:0] v;
    case (idx)
      5'd0:    v = 24'd737280;
      5'd1:    v = 24'd435242;
      5'd2:    v = 24'd229970;
      5'd3:    v = 24'd116736;
      5'd4:    v = 24'd58595;
      5'd5:    v = 24'd29326;
      5'd6:    v = 24'd14667;
      5'd7:    v = 24'd7334;
      5'd8:    v = 24'd3667;
      5'd9:    v = 24'd1833;
      5'd10:   v = 24'd917;
      5'd11:   v = 24'd458;
      5'd12:   v = 24'd229;
      5'd13:   v = 24'd115;
      5'd14:   v = 24'd57;
      5'd15:   v = 24'd29;
      5'd16:   v = 24'd14;
      5'd17:   v = 24'd7;
      5'd18:   v = 24'd4;
      5'd19:   v = 24'd2;
      5'd20:   v = 24'd1;
      default: v = 24'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/tilt_complementary_filter_unit.sv =====
// Top level of the tilt complementary filter: sequencer, shared multiplier, state and ports.
`timescale 1ns / 1ps

// Tilt complementary filter.
// Input channel (in_valid / in_stall): one beat per sample with raw gyro X rate and
// accelerometer Y and Z. Result channel (out_valid / out_stall): one beat per sample,
// the filtered tilt angle in 1/64 degree, saturated to +-180 degrees.
// Config channel (cfg_valid / cfg_ready, always ready): index 0 blend weight (fraction
// of 65536), index 1 sample period in ms. Write only while the block is idle.
// Sequence: a sample is accepted only in idle (in_stall is low there). It then passes
// through the gyro multiply state, the iteration state (CORDIC micro-rotations, with the
// gyro reciprocal estimate and its correction on the multiplier at its start), predict,
// blend multiply and write-back; out_valid rises as the sequencer returns to idle, where
// the next sample can be taken. Throughput is set by the iteration loop.
// The blend reuses the same 25x18 multiplier as the gyro scaling and division.
// The result sits in an output register; the next sample can be accepted while it waits.
// If the receiver stalls, the following result holds in write-back until the register
// frees, and the angle state only advances when its result is loaded.
// Reset (rst_n low, synchronous): angle state to zero, registers to their defaults,
// output beat dropped.
module tilt_complementary_filter_unit #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [15:0]                in_gyro_rate_raw,
  input  logic signed [15:0]                in_accel_y_raw,
  input  logic signed [15:0]                in_accel_z_raw,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [14:0]                out_tilt_angle,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tcf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tcf_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import tcf_pkg::*;

  localparam int NITER = (CORDIC_ITERATIONS > TABLE_LEN) ? TABLE_LEN : CORDIC_ITERATIONS;
  localparam int STEPS = (NITER > GYRO_STEPS) ? NITER : GYRO_STEPS;
  localparam int CNT_W = $clog2(STEPS + 1);

  localparam logic signed [MUL_P_W-1:0] LIM_POS = MUL_P_W'(ANG_LIMIT);
  localparam logic signed [MUL_P_W-1:0] LIM_NEG = -MUL_P_W'(ANG_LIMIT);
  localparam logic signed [MUL_P_W-1:0] RND_HALF = MUL_P_W'(32768);

  // ---- configuration registers ----
  logic [15:0] blend_weight_r;
  logic [7:0]  period_ms_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blend_weight_r <= BLEND_WEIGHT_RST;
      period_ms_r    <= PERIOD_MS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BLEND_WEIGHT:     blend_weight_r <= cfg_wdata;
        REG_SAMPLE_PERIOD_MS: period_ms_r    <= cfg_wdata[7:0];
        default: ;   // unmapped index, write dropped
      endcase
    end
  end

  // ---- sequencer ----
  tcf_state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic in_accept, out_free, out_valid_r;
  tcf_iter_ctl_t cordic_ctl, div_ctl;
  logic pred_load, prod_load, result_load;

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:       if (in_accept) state_nxt = ST_GYRO_MUL;
      ST_GYRO_MUL:   state_nxt = ST_ITERATE;
      ST_ITERATE:    if (cnt_r == CNT_W'(STEPS-1)) state_nxt = ST_PREDICT;
      ST_PREDICT:    state_nxt = ST_BLEND_MUL;
      ST_BLEND_MUL:  state_nxt = ST_WRITE_BACK;
      ST_WRITE_BACK: if (out_free) state_nxt = ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall        = 1'b1;
    cordic_ctl      = '0;
    div_ctl         = '0;
    pred_load       = 1'b0;
    prod_load       = 1'b0;
    result_load     = 1'b0;
    cnt_nxt         = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall        = 1'b0;
        cordic_ctl.load = in_valid;
      end
      ST_GYRO_MUL: begin
        div_ctl.load = 1'b1;
      end
      ST_ITERATE: begin
        cordic_ctl.step = (cnt_r < CNT_W'(NITER));
        div_ctl.step    = (cnt_r < CNT_W'(GYRO_STEPS));
        cnt_nxt         = cnt_r + 1'b1;
      end
      ST_PREDICT:    pred_load   = 1'b1;
      ST_BLEND_MUL:  prod_load   = 1'b1;
      ST_WRITE_BACK: result_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // ---- sample capture ----
  logic signed [15:0] gyro_r;

  always_ff @(posedge clk) begin
    if (in_accept) gyro_r <= in_gyro_rate_raw;
  end

  // ---- gravity angle ----
  logic signed [ANG_W-1:0] grav_angle;

  tcf_cordic u_cordic (
    .clk        (clk),
    .ctl        (cordic_ctl),
    .accel_y    (in_accel_y_raw),
    .accel_z    (in_accel_z_raw),
    .shift_idx  (TAB_IDX_W'(cnt_r)),
    .grav_angle (grav_angle)
  );

  // ---- shared multiplier ----
  // gyro: |raw| * period, then the divider's estimate and check;
  // blend: w * (gravity - predicted)
  logic signed [16:0]          gyro_abs;
  logic signed [MUL_A_W-1:0]   mul_a, div_op_a;
  logic signed [MUL_B_W-1:0]   mul_b, div_op_b;
  logic signed [MUL_P_W-1:0]   mul_p;
  logic signed [PRED_W-1:0]    pred_r;

  assign gyro_abs = gyro_r[15] ? -{gyro_r[15], gyro_r} : {gyro_r[15], gyro_r};

  always_comb begin
    if (state_r == ST_GYRO_MUL) begin
      mul_a = MUL_A_W'(gyro_abs);
      mul_b = $signed({{(MUL_B_W-8){1'b0}}, period_ms_r});
    end else if (state_r == ST_ITERATE) begin
      mul_a = div_op_a;
      mul_b = div_op_b;
    end else begin
      mul_a = MUL_A_W'(grav_angle) - MUL_A_W'(pred_r);
      mul_b = $signed({{(MUL_B_W-16){1'b0}}, blend_weight_r});
    end
  end

  assign mul_p = mul_a * mul_b;

  // ---- gyro increment divider ----
  logic [DIV_Q_BITS-1:0] gyro_q;

  tcf_gyro_div u_gyro_div (
    .clk      (clk),
    .ctl      (div_ctl),
    .mul_p    (mul_p),
    .op_a     (div_op_a),
    .op_b     (div_op_b),
    .quotient (gyro_q)
  );

  // ---- predict, blend, write back ----
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [PRED_W-1:0]  gyro_inc;
  logic signed [MUL_P_W-1:0] prod_r, blend_sum, acc_wide;
  logic signed [ACC_W-1:0]   acc_nxt;
  logic signed [14:0]        tilt_r;

  assign gyro_inc = gyro_r[15] ? -$signed(PRED_W'(gyro_q)) : $signed(PRED_W'(gyro_q));

  always_ff @(posedge clk) begin
    if (pred_load) pred_r <= PRED_W'(acc_r) + gyro_inc;
    if (prod_load) prod_r <= mul_p;
  end

  // (65536-w)*pred + w*grav = 65536*pred + w*(grav-pred)
  always_comb begin
    blend_sum = (prod_r + RND_HALF) >>> 16;
    acc_wide  = MUL_P_W'(pred_r) + blend_sum;
    if (acc_wide > LIM_POS)      acc_nxt = ACC_W'(LIM_POS);
    else if (acc_wide < LIM_NEG) acc_nxt = ACC_W'(LIM_NEG);
    else                         acc_nxt = acc_wide[ACC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (result_load) begin
        acc_r       <= acc_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) tilt_r <= acc_nxt[ACC_W-1:8];
  end

  assign out_valid      = out_valid_r;
  assign out_tilt_angle = tilt_r;

  // ---- checks ----
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRITE_BACK && out_valid_r && out_stall) |=> state_r == ST_WRITE_BACK)
    else $error("pending result beat would be overwritten");

  a_acc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_r <= ACC_W'(ANG_LIMIT)) && (acc_r >= -ACC_W'(ANG_LIMIT)))
    else $error("angle state beyond 180 degrees");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == ST_GYRO_MUL) && !out_valid_r || (state_r == ST_GYRO_MUL))
    else $error("accepted beat did not start the sequence");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ITERATE) |-> (cnt_r <= CNT_W'(STEPS-1)))
    else $error("iteration counter past last step");

endmodule

// ===== design/tcf_cordic.sv =====
// Vectoring CORDIC, one micro-rotation per step, giving atan2(y, z) in 1/16384 degree.
`timescale 1ns / 1ps

module tcf_cordic (
  input  logic                              clk,
  input  tcf_pkg::tcf_iter_ctl_t            ctl,
  input  logic signed [15:0]                accel_y,
  input  logic signed [15:0]                accel_z,
  input  logic [tcf_pkg::TAB_IDX_W-1:0]     shift_idx,
  output logic signed [tcf_pkg::ANG_W-1:0]  grav_angle
);
  import tcf_pkg::*;

  localparam logic signed [ANG_W-1:0] LIM_POS = ANG_W'(ANG_LIMIT);
  localparam logic signed [ANG_W-1:0] LIM_NEG = -ANG_W'(ANG_LIMIT);

  logic signed [CORDIC_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [CORDIC_W-1:0] dx, dy, x_init, y_init;
  logic signed [ANG_W-1:0]    ang_r, ang_nxt, rot;
  logic                       zero_r, zero_nxt;

  always_comb begin
    x_init   = {{(CORDIC_W-32){accel_z[15]}}, accel_z, 16'h0000};
    y_init   = {{(CORDIC_W-32){accel_y[15]}}, accel_y, 16'h0000};
    dx       = y_r >>> shift_idx;
    dy       = x_r >>> shift_idx;
    rot      = $signed(atan_lookup(shift_idx));
    x_nxt    = x_r;
    y_nxt    = y_r;
    ang_nxt  = ang_r;
    zero_nxt = zero_r;
    if (ctl.load) begin
      zero_nxt = (accel_y == 16'sd0) && (accel_z == 16'sd0);
      if (accel_z[15]) begin
        // left half plane: pre-rotate by 180, sign of offset follows y
        x_nxt   = -x_init;
        y_nxt   = -y_init;
        ang_nxt = accel_y[15] ? LIM_NEG : LIM_POS;
      end else begin
        x_nxt   = x_init;
        y_nxt   = y_init;
        ang_nxt = '0;
      end
    end else if (ctl.step) begin
      if (!y_r[CORDIC_W-1]) begin
        x_nxt   = x_r + dx;
        y_nxt   = y_r - dy;
        ang_nxt = ang_r + rot;
      end else begin
        x_nxt   = x_r - dx;
        y_nxt   = y_r + dy;
        ang_nxt = ang_r - rot;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    ang_r  <= ang_nxt;
    zero_r <= zero_nxt;
  end

  always_comb begin
    if (zero_r)                grav_angle = '0;
    else if (ang_r > LIM_POS)  grav_angle = LIM_POS;
    else if (ang_r < LIM_NEG)  grav_angle = LIM_NEG;
    else                       grav_angle = ang_r;
  end

endmodule

// ===== design/tcf_gyro_div.sv =====
// Gyro increment divider by the fixed scale constant: reciprocal estimate and one correction.
`timescale 1ns / 1ps

module tcf_gyro_div (
  input  logic                               clk,
  input  tcf_pkg::tcf_iter_ctl_t             ctl,
  input  logic signed [tcf_pkg::MUL_P_W-1:0] mul_p,
  output logic signed [tcf_pkg::MUL_A_W-1:0] op_a,
  output logic signed [tcf_pkg::MUL_B_W-1:0] op_b,
  output logic [tcf_pkg::DIV_Q_BITS-1:0]     quotient
);
  import tcf_pkg::*;

  // estimate is never high and at most one low, so one correction step
  logic [MAG_W-1:0]      mag_r, mag_nxt;
  logic [DIV_Q_BITS-1:0] q_r, q_nxt;
  logic                  est_done_r, est_done_nxt;
  logic [DIV_NUM_W-1:0]  numer, resid;

  always_comb begin
    numer        = DIV_NUM_W'({mag_r, 11'b0}) + DIV_NUM_W'(DIV_BIAS);
    resid        = numer - mul_p[DIV_NUM_W-1:0];
    mag_nxt      = mag_r;
    q_nxt        = q_r;
    est_done_nxt = est_done_r;
    if (ctl.load) begin
      mag_nxt      = mul_p[MAG_W-1:0];
      est_done_nxt = 1'b0;
    end else if (ctl.step) begin
      if (!est_done_r) begin
        q_nxt        = mul_p[RECIP_SH +: DIV_Q_BITS];
        est_done_nxt = 1'b1;
      end else if (resid >= DIV_NUM_W'(DIV_CONST)) begin
        q_nxt = q_r + 1'b1;
      end
    end
  end

  // operands for the shared multiplier
  always_comb begin
    if (!est_done_r) begin
      op_a = $signed({{(MUL_A_W-MAG_W){1'b0}}, mag_r});
      op_b = MUL_B_W'(RECIP);
    end else begin
      op_a = $signed({{(MUL_A_W-DIV_Q_BITS){1'b0}}, q_r});
      op_b = MUL_B_W'(DIV_CONST);
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    q_r        <= q_nxt;
    est_done_r <= est_done_nxt;
  end

  assign quotient = q_r;

endmodule
